FILE: src/ts_pmt_section_parser_macros.svh
// Assertion macros for the program map section parser.
`ifndef TS_PMT_SECTION_PARSER_MACROS_SVH
`define TS_PMT_SECTION_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TPP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ts_pmt_pkg.sv
// Types, field codes and helpers for the program map section parser.
package ts_pmt_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [3:0] FldPointer   = 4'd0;
   localparam logic [3:0] FldTableId   = 4'd1;
   localparam logic [3:0] FldSyntax    = 4'd2;
   localparam logic [3:0] FldLength    = 4'd3;
   localparam logic [3:0] FldProgram   = 4'd4;
   localparam logic [3:0] FldVersion   = 4'd5;
   localparam logic [3:0] FldCurNext   = 4'd6;
   localparam logic [3:0] FldSection   = 4'd7;
   localparam logic [3:0] FldLastSec   = 4'd8;
   localparam logic [3:0] FldPcrPid    = 4'd9;
   localparam logic [3:0] FldProgInfo  = 4'd10;
   localparam logic [3:0] FldStreamTyp = 4'd11;
   localparam logic [3:0] FldEsPid     = 4'd12;
   localparam logic [3:0] FldEsInfo    = 4'd13;
   localparam logic [3:0] FldCrc       = 4'd14;
   localparam logic [3:0] FldError     = 4'd15;

   localparam logic [31:0] ErrShortLen = 32'd1;
   localparam logic [31:0] ErrOverrun  = 32'd2;

   localparam logic [1:0] ClsOther = 2'd0;
   localparam logic [1:0] ClsAudio = 2'd1;
   localparam logic [1:0] ClsVideo = 2'd2;

   localparam logic [9:0] FixedHdrBytes = 10'd13;
   localparam logic [9:0] EntryHdrBytes = 10'd5;

   typedef struct packed {
      logic [3:0]  field_id;
      logic [31:0] field_value;
      logic [7:0]  entry_index;
      logic [1:0]  stream_class;
      logic        last_of_run;
      logic        section_done;
   } rec_type;

   function automatic rec_type make_rec(logic [3:0] id, logic [31:0] val,
                                        logic [7:0] idx, logic [1:0] cls,
                                        logic done);
      rec_type r;
      r.field_id     = id;
      r.field_value  = val;
      r.entry_index  = idx;
      r.stream_class = cls;
      r.last_of_run  = 1'b0;
      r.section_done = done;
      return r;
   endfunction

   function automatic logic [1:0] class_of(logic [7:0] t);
      logic [1:0] c;
      case (t)
         8'h03, 8'h04, 8'h0F, 8'h11, 8'h1C, 8'h81, 8'h82: c = ClsAudio;
         8'h01, 8'h02, 8'h1B, 8'h1E, 8'h42:               c = ClsVideo;
         default:                                          c = ClsOther;
      endcase
      return c;
   endfunction

endpackage

FILE: src/ts_pmt_section_parser.sv
// Program map section parser: byte stream in, decoded field records out.
//
// Input channel req_: one section byte per beat, req_tuser high on the
// pointer_field byte, which restarts the parser from any state.
// Output channel rsp_: one decoded field per beat; rsp_tlast marks the final
// record caused by one input byte, rsp_tuser marks the record (CRC or error)
// that ends a section. Bytes outside a section produce no record.
// Each byte is decoded in the cycle it is accepted and its zero, one or two
// records land in a four-entry result queue; the first record is visible on
// rsp_ no earlier than the cycle after the byte is accepted.
// Throughput: one byte per cycle while the receiver takes one record per
// cycle; only the version byte, a short-length error and an ES info length
// overrun yield two records.
// req_tready is high while the queue has room for two records, so a stalled
// receiver holds the input once three records wait; bytes that yield no
// record keep passing until then.
// Reset (synchronous) empties the queue and returns the parser to waiting
// for a pointer_field byte.
`include "ts_pmt_section_parser_macros.svh"

module ts_pmt_section_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] section_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [3:0] field_id, [35:4] field_value,
                                    // [43:36] entry_index, [45:44] stream_class
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // [0] section_done
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_TABLE, PH_LEN_HI, PH_LEN_LO, PH_PROG_HI, PH_PROG_LO,
      PH_VER, PH_SEC, PH_LAST, PH_PCR_HI, PH_PCR_LO, PH_PIL_HI, PH_PIL_LO,
      PH_PSKIP, PH_ES_TYPE, PH_PID_HI, PH_PID_LO, PH_ESL_HI, PH_ESL_LO,
      PH_ESKIP, PH_CRC0, PH_CRC1, PH_CRC2, PH_CRC3
   } phase_type;

   localparam int PtrW = ts_pmt_pkg::QueuePtrW;
   localparam int CntW = ts_pmt_pkg::QueuePtrW + 1;
   localparam logic [CntW-1:0] Depth = CntW'(ts_pmt_pkg::QueueDepth);

   phase_type phase_ff, phase_in;
   logic [9:0]  skip_ff, skip_in;
   logic [9:0]  loop_ff, loop_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  entry_ff, entry_in;

   ts_pmt_pkg::rec_type queue_ff [ts_pmt_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   ts_pmt_pkg::rec_type rec0, rec1, head;
   logic [1:0]  n_rec;
   logic        push, pop;
   logic [7:0]  b;
   logic [9:0]  v10;
   logic [10:0] need;
   logic [9:0]  skip_dec;
   logic [7:0]  entry_inc;
   logic [9:0]  loop_after;

   assign b          = req_tdata;
   assign req_tready = (count_ff <= Depth - CntW'(2));
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign skip_dec   = skip_ff - 10'd1;
   assign entry_inc  = (entry_ff == 8'hFF) ? entry_ff : entry_ff + 8'd1;
   assign v10        = {acc_ff[9:8], b};
   assign need       = {1'b0, ts_pmt_pkg::FixedHdrBytes} + {1'b0, v10};

   // Byte decode: next state and up to two records.
   always_comb begin
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      loop_in    = loop_ff;
      acc_in     = acc_ff;
      entry_in   = entry_ff;
      rec0       = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldPointer, 32'd0, 8'd0,
                                        ts_pmt_pkg::ClsOther, 1'b0);
      rec1       = rec0;
      n_rec      = 2'd0;
      loop_after = loop_ff - v10;
      if (req_tuser) begin
         skip_in  = 10'd0;
         loop_in  = 10'd0;
         acc_in   = 32'd0;
         entry_in = 8'd0;
         rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldPointer, {24'd0, b}, 8'd0,
                                         ts_pmt_pkg::ClsOther, 1'b0);
         n_rec    = 2'd1;
         phase_in = PH_TABLE;
      end else begin
         case (phase_ff)
            PH_TABLE: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldTableId, {24'd0, b},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldSyntax, {31'd0, b[7]},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               acc_in   = {22'd0, b[1:0], 8'd0};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldLength, {22'd0, v10},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               loop_in  = v10;
               phase_in = PH_PROG_HI;
            end
            PH_PROG_HI: begin
               acc_in   = {16'd0, b, 8'd0};
               phase_in = PH_PROG_LO;
            end
            PH_PROG_LO: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldProgram,
                                               {16'd0, acc_ff[15:8], b},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_VER;
            end
            PH_VER: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldVersion,
                                               {27'd0, b[5:1]},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               rec1     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldCurNext,
                                               {31'd0, b[0]},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd2;
               phase_in = PH_SEC;
            end
            PH_SEC: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldSection, {24'd0, b},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_LAST;
            end
            PH_LAST: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldLastSec, {24'd0, b},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_PCR_HI;
            end
            PH_PCR_HI: begin
               acc_in   = {19'd0, b[4:0], 8'd0};
               phase_in = PH_PCR_LO;
            end
            PH_PCR_LO: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldPcrPid,
                                               {19'd0, acc_ff[12:8], b},
                                               8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_PIL_HI;
            end
            PH_PIL_HI: begin
               acc_in   = {22'd0, b[1:0], 8'd0};
               phase_in = PH_PIL_LO;
            end
            PH_PIL_LO: begin
               rec0  = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldProgInfo, {22'd0, v10},
                                            8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec = 2'd1;
               if ({1'b0, loop_ff} < need) begin
                  // section too short for the header plus program descriptors
                  rec1     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldError,
                                                  ts_pmt_pkg::ErrShortLen, 8'd0,
                                                  ts_pmt_pkg::ClsOther, 1'b1);
                  n_rec    = 2'd2;
                  phase_in = PH_IDLE;
               end else begin
                  loop_in = loop_ff - need[9:0];
                  skip_in = v10;
                  if (v10 != 10'd0) begin
                     phase_in = PH_PSKIP;
                  end else begin
                     phase_in = (loop_ff == need[9:0]) ? PH_CRC0 : PH_ES_TYPE;
                  end
               end
            end
            PH_PSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 10'd0) begin
                  phase_in = (loop_ff == 10'd0) ? PH_CRC0 : PH_ES_TYPE;
               end
            end
            PH_ES_TYPE: begin
               n_rec = 2'd1;
               if (loop_ff < ts_pmt_pkg::EntryHdrBytes) begin
                  rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldError,
                                                  ts_pmt_pkg::ErrOverrun, 8'd0,
                                                  ts_pmt_pkg::ClsOther, 1'b1);
                  phase_in = PH_IDLE;
               end else begin
                  rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldStreamTyp,
                                                  {24'd0, b}, entry_ff,
                                                  ts_pmt_pkg::class_of(b), 1'b0);
                  loop_in  = loop_ff - ts_pmt_pkg::EntryHdrBytes;
                  phase_in = PH_PID_HI;
               end
            end
            PH_PID_HI: begin
               acc_in   = {19'd0, b[4:0], 8'd0};
               phase_in = PH_PID_LO;
            end
            PH_PID_LO: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldEsPid,
                                               {19'd0, acc_ff[12:8], b}, entry_ff,
                                               ts_pmt_pkg::ClsOther, 1'b0);
               n_rec    = 2'd1;
               phase_in = PH_ESL_HI;
            end
            PH_ESL_HI: begin
               acc_in   = {22'd0, b[1:0], 8'd0};
               phase_in = PH_ESL_LO;
            end
            PH_ESL_LO: begin
               rec0  = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldEsInfo, {22'd0, v10},
                                            entry_ff, ts_pmt_pkg::ClsOther, 1'b0);
               n_rec = 2'd1;
               if (v10 > loop_ff) begin
                  rec1     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldError,
                                                  ts_pmt_pkg::ErrOverrun, 8'd0,
                                                  ts_pmt_pkg::ClsOther, 1'b1);
                  n_rec    = 2'd2;
                  phase_in = PH_IDLE;
               end else begin
                  loop_in = loop_after;
                  skip_in = v10;
                  if (v10 != 10'd0) begin
                     phase_in = PH_ESKIP;
                  end else begin
                     entry_in = entry_inc;
                     phase_in = (loop_after == 10'd0) ? PH_CRC0 : PH_ES_TYPE;
                  end
               end
            end
            PH_ESKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 10'd0) begin
                  entry_in = entry_inc;
                  phase_in = (loop_ff == 10'd0) ? PH_CRC0 : PH_ES_TYPE;
               end
            end
            PH_CRC0: begin
               acc_in   = {b, 24'd0};
               phase_in = PH_CRC1;
            end
            PH_CRC1: begin
               acc_in   = {acc_ff[31:24], b, 16'd0};
               phase_in = PH_CRC2;
            end
            PH_CRC2: begin
               acc_in   = {acc_ff[31:16], b, 8'd0};
               phase_in = PH_CRC3;
            end
            PH_CRC3: begin
               rec0     = ts_pmt_pkg::make_rec(ts_pmt_pkg::FldCrc,
                                               {acc_ff[31:8], b}, 8'd0,
                                               ts_pmt_pkg::ClsOther, 1'b1);
               n_rec    = 2'd1;
               phase_in = PH_IDLE;
            end
            default: begin
               // waiting for a pointer_field byte: drop
            end
         endcase
      end
      // flag the final record of this byte
      if (n_rec == 2'd2) begin
         rec1.last_of_run = 1'b1;
      end else begin
         rec0.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         skip_ff  <= 10'd0;
         loop_ff  <= 10'd0;
         acc_ff   <= 32'd0;
         entry_ff <= 8'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         loop_ff  <= loop_in;
         acc_ff   <= acc_in;
         entry_ff <= entry_in;
      end
   end

   // Result queue: up to two writes and one read per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && n_rec != 2'd0) begin
            queue_ff[wr_ptr_ff] <= rec0;
            if (n_rec == 2'd2) begin
               queue_ff[wr_ptr_ff + PtrW'(1)] <= rec1;
            end
            wr_ptr_ff <= wr_ptr_ff + PtrW'(n_rec);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_ff + (push ? CntW'(n_rec) : CntW'(0))
                     - (pop ? CntW'(1) : CntW'(0));
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {2'b00, head.stream_class, head.entry_index,
                        head.field_value, head.field_id};
   assign rsp_tlast  = head.last_of_run;
   assign rsp_tuser  = head.section_done;

   `TPP_ASSERT_IMP(a_queue_bound, 1'b1, count_ff <= Depth, "result queue overfilled")
   `TPP_ASSERT_IMP(a_done_is_last, rsp_tvalid && rsp_tuser, rsp_tlast,
                   "section end record not last of its byte")
   `TPP_ASSERT_NXT(a_two_records, push && !req_tuser && phase_ff == PH_VER && !pop,
                   count_ff == $past(count_ff) + CntW'(2),
                   "version byte did not queue two records")

endmodule

FILE: dv/ts_pmt_field_checker.sv
// Field checker for the program map section parser: predicts records and compares them.
`timescale 1ns / 100ps

module ts_pmt_field_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   output int          mismatch_count,
   output int          fields_pending,
   output int          fields_checked
);

   typedef enum logic [4:0] {
      PhIdle, PhTable, PhLenHi, PhLenLo, PhProgHi, PhProgLo, PhVer, PhSec, PhLast,
      PhPcrHi, PhPcrLo, PhPilHi, PhPilLo, PhProgSkip, PhEsType, PhPidHi, PhPidLo,
      PhEslHi, PhEslLo, PhEsSkip, PhCrc0, PhCrc1, PhCrc2, PhCrc3
   } parse_phase_type;

   parse_phase_type     phase;
   logic [9:0]          skip_left;
   logic [11:0]         loop_left;
   logic [31:0]         acc;
   logic [7:0]          entry_cnt;
   ts_pmt_pkg::rec_type expected_fields[$];
   ts_pmt_pkg::rec_type got;
   ts_pmt_pkg::rec_type want;

   function automatic logic [1:0] stream_kind(logic [7:0] t);
      if (t inside {8'h01, 8'h02, 8'h1B, 8'h1E, 8'h42})
         return ts_pmt_pkg::ClsVideo;
      if (t inside {8'h03, 8'h04, 8'h0F, 8'h11, 8'h1C, 8'h81, 8'h82})
         return ts_pmt_pkg::ClsAudio;
      return ts_pmt_pkg::ClsOther;
   endfunction

   task automatic push_field(logic [3:0] id, logic [31:0] val, logic [7:0] idx,
                             logic [1:0] cls, logic done);
      ts_pmt_pkg::rec_type r;
      r.field_id     = id;
      r.field_value  = val;
      r.entry_index  = idx;
      r.stream_class = cls;
      r.last_of_run  = 1'b0;
      r.section_done = done;
      expected_fields.push_back(r);
   endtask

   task automatic raise_error(logic [31:0] code);
      push_field(ts_pmt_pkg::FldError, code, 8'd0, ts_pmt_pkg::ClsOther, 1'b1);
      phase = PhIdle;
   endtask

   // With the loop used up, the next four bytes carry the CRC.
   task automatic next_entry_or_crc();
      phase = (loop_left == 12'd0) ? PhCrc0 : PhEsType;
   endtask

   task automatic decode_section_byte(logic [7:0] b, logic start);
      int          n_before;
      logic [31:0] v;
      logic [7:0]  idx;
      n_before = expected_fields.size();
      idx = entry_cnt;
      v = {24'd0, b};
      if (start) begin
         skip_left = '0;
         loop_left = '0;
         acc = '0;
         entry_cnt = '0;
         push_field(ts_pmt_pkg::FldPointer, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
         phase = PhTable;
      end else begin
         case (phase)
            PhTable: begin
               push_field(ts_pmt_pkg::FldTableId, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhLenHi;
            end
            PhLenHi: begin
               push_field(ts_pmt_pkg::FldSyntax, {31'd0, b[7]}, 8'd0,
                          ts_pmt_pkg::ClsOther, 1'b0);
               acc = {22'd0, b[1:0], 8'd0};
               phase = PhLenLo;
            end
            PhLenLo: begin
               v = acc | b;
               loop_left = v[11:0];
               push_field(ts_pmt_pkg::FldLength, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhProgHi;
            end
            PhProgHi: begin
               acc = {16'd0, b, 8'd0};
               phase = PhProgLo;
            end
            PhProgLo: begin
               push_field(ts_pmt_pkg::FldProgram, acc | b, 8'd0,
                          ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhVer;
            end
            PhVer: begin
               push_field(ts_pmt_pkg::FldVersion, {27'd0, b[5:1]}, 8'd0,
                          ts_pmt_pkg::ClsOther, 1'b0);
               push_field(ts_pmt_pkg::FldCurNext, {31'd0, b[0]}, 8'd0,
                          ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhSec;
            end
            PhSec: begin
               push_field(ts_pmt_pkg::FldSection, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhLast;
            end
            PhLast: begin
               push_field(ts_pmt_pkg::FldLastSec, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhPcrHi;
            end
            PhPcrHi: begin
               acc = {19'd0, b[4:0], 8'd0};
               phase = PhPcrLo;
            end
            PhPcrLo: begin
               push_field(ts_pmt_pkg::FldPcrPid, acc | b, 8'd0,
                          ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhPilHi;
            end
            PhPilHi: begin
               acc = {22'd0, b[1:0], 8'd0};
               phase = PhPilLo;
            end
            PhPilLo: begin
               v = acc | b;
               push_field(ts_pmt_pkg::FldProgInfo, v, 8'd0, ts_pmt_pkg::ClsOther, 1'b0);
               if (int'(loop_left) < int'(ts_pmt_pkg::FixedHdrBytes) + int'(v)) begin
                  raise_error(ts_pmt_pkg::ErrShortLen);
               end else begin
                  loop_left = loop_left - {2'd0, ts_pmt_pkg::FixedHdrBytes} - v[11:0];
                  skip_left = v[9:0];
                  if (v != 0)
                     phase = PhProgSkip;
                  else
                     next_entry_or_crc();
               end
            end
            PhProgSkip: begin
               skip_left = skip_left - 10'd1;
               if (skip_left == 10'd0)
                  next_entry_or_crc();
            end
            PhEsType: begin
               if (loop_left < {2'd0, ts_pmt_pkg::EntryHdrBytes}) begin
                  raise_error(ts_pmt_pkg::ErrOverrun);
               end else begin
                  loop_left = loop_left - {2'd0, ts_pmt_pkg::EntryHdrBytes};
                  push_field(ts_pmt_pkg::FldStreamTyp, v, idx, stream_kind(b), 1'b0);
                  phase = PhPidHi;
               end
            end
            PhPidHi: begin
               acc = {19'd0, b[4:0], 8'd0};
               phase = PhPidLo;
            end
            PhPidLo: begin
               push_field(ts_pmt_pkg::FldEsPid, acc | b, idx, ts_pmt_pkg::ClsOther, 1'b0);
               phase = PhEslHi;
            end
            PhEslHi: begin
               acc = {22'd0, b[1:0], 8'd0};
               phase = PhEslLo;
            end
            PhEslLo: begin
               v = acc | b;
               push_field(ts_pmt_pkg::FldEsInfo, v, idx, ts_pmt_pkg::ClsOther, 1'b0);
               if (int'(v) > int'(loop_left)) begin
                  raise_error(ts_pmt_pkg::ErrOverrun);
               end else begin
                  loop_left = loop_left - v[11:0];
                  skip_left = v[9:0];
                  if (v != 0) begin
                     phase = PhEsSkip;
                  end else begin
                     if (entry_cnt != 8'hFF)
                        entry_cnt = entry_cnt + 8'd1;
                     next_entry_or_crc();
                  end
               end
            end
            PhEsSkip: begin
               skip_left = skip_left - 10'd1;
               if (skip_left == 10'd0) begin
                  if (entry_cnt != 8'hFF)
                     entry_cnt = entry_cnt + 8'd1;
                  next_entry_or_crc();
               end
            end
            PhCrc0: begin
               acc = {b, 24'd0};
               phase = PhCrc1;
            end
            PhCrc1: begin
               acc = acc | {8'd0, b, 16'd0};
               phase = PhCrc2;
            end
            PhCrc2: begin
               acc = acc | {16'd0, b, 8'd0};
               phase = PhCrc3;
            end
            PhCrc3: begin
               push_field(ts_pmt_pkg::FldCrc, acc | b, 8'd0, ts_pmt_pkg::ClsOther, 1'b1);
               phase = PhIdle;
            end
            default: ;  // waiting for a pointer byte: drop
         endcase
      end
      if (expected_fields.size() > n_before)
         expected_fields[expected_fields.size() - 1].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = PhIdle;
         skip_left = '0;
         loop_left = '0;
         acc = '0;
         entry_cnt = '0;
         expected_fields.delete();
      end else begin
         // Records are registered after their byte, so check before predicting.
         if (rsp_tvalid && rsp_tready) begin
            got.field_id     = rsp_tdata[3:0];
            got.field_value  = rsp_tdata[35:4];
            got.entry_index  = rsp_tdata[43:36];
            got.stream_class = rsp_tdata[45:44];
            got.last_of_run  = rsp_tlast;
            got.section_done = rsp_tuser;
            fields_checked = fields_checked + 1;
            if (expected_fields.size() == 0) begin
               $display({"%0t: unexpected record: expected none, got id %0d value %h",
                         " idx %0d cls %0d last %b done %b"},
                        $time, got.field_id, got.field_value, got.entry_index,
                        got.stream_class, got.last_of_run, got.section_done);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_fields.pop_front();
               if (got !== want) begin
                  $display({"%0t: record mismatch: expected id %0d value %h idx %0d cls %0d",
                            " last %b done %b, got id %0d value %h idx %0d cls %0d",
                            " last %b done %b"},
                           $time, want.field_id, want.field_value, want.entry_index,
                           want.stream_class, want.last_of_run, want.section_done,
                           got.field_id, got.field_value, got.entry_index,
                           got.stream_class, got.last_of_run, got.section_done);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            decode_section_byte(req_tdata, req_tuser);
      end
      fields_pending = expected_fields.size();
   end

endmodule

FILE: dv/ts_pmt_section_parser_tb.sv
// Testbench top for the program map section parser: section stimulus, flow control, verdict.
`timescale 1ns / 100ps

module ts_pmt_section_parser_tb;

   localparam int HoldOffCycles  = 80;
   localparam int WatchdogLimit  = 1000;
   localparam int BytesPerPhase  = 155;
   localparam int DrainCycles    = 16;
   localparam int MaxSectionLen  = 1023;

   typedef enum int {FaultNone, FaultShortLen, FaultTypeOverrun, FaultEsOverrun,
                     FaultRestart} section_fault_type;
   typedef enum int {PatRandom, PatZeros, PatOnes} fill_pattern_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;  // [7:0] data_byte
   logic        req_tuser  = 1'b0;  // [0] section_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // [3:0] field_id, [35:4] field_value,
                                    // [43:36] entry_index, [45:44] stream_class
   logic        rsp_tlast;          // last_of_run
   logic        rsp_tuser;          // [0] section_done

   int   mismatch_count;
   int   fields_pending;
   int   fields_checked;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_off_req   = 1'b0;
   int   quiet_cycles   = 0;
   int   bytes_sent     = 0;
   int   sections_sent  = 0;
   int   sections_faulted = 0;

   ts_pmt_section_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   ts_pmt_field_checker u_field_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .fields_pending (fields_pending),
      .fields_checked (fields_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WatchdogLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
            $display("ts_pmt_section_parser test failed");
            $finish;
         end
      end
   end

   function automatic logic [7:0] fill_byte(fill_pattern_type pat);
      case (pat)
         PatZeros: return 8'h00;
         PatOnes:  return 8'hFF;
         default:  return 8'($urandom);
      endcase
   endfunction

   // Reserved bits come from the pattern, the two length bits from len.
   function automatic logic [7:0] len_hi_byte(fill_pattern_type pat, logic [9:0] len);
      logic [7:0] f;
      f = fill_byte(pat);
      return {f[7:2], len[9:8]};
   endfunction

   function automatic logic [7:0] pick_stream_type();
      case ($urandom_range(0, 15))
         0:  return 8'h01;
         1:  return 8'h02;
         2:  return 8'h03;
         3:  return 8'h04;
         4:  return 8'h0F;
         5:  return 8'h11;
         6:  return 8'h1B;
         7:  return 8'h1C;
         8:  return 8'h1E;
         9:  return 8'h42;
         10: return 8'h81;
         11: return 8'h82;
         default: return 8'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic offer_section_byte(logic [7:0] value, logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic stop_offering();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_all_fields();
      while (fields_pending != 0) @(negedge clock);
   endtask

   task automatic send_pmt_section(int pil, int n_ent, int esl_max,
                                   section_fault_type fault, fill_pattern_type pat);
      logic [7:0]  body[$];
      int          esl[$];
      int          total;
      int          sec_len;
      int          cut;
      int          last;
      logic [9:0]  len10;
      if (fault == FaultEsOverrun && n_ent == 0)
         n_ent = 1;
      total = int'(ts_pmt_pkg::FixedHdrBytes) + pil;
      for (int i = 0; i < n_ent; i++) begin
         esl.push_back($urandom_range(0, esl_max));
         total += int'(ts_pmt_pkg::EntryHdrBytes) + esl[i];
      end
      last = n_ent - 1;
      if (fault == FaultEsOverrun && esl[last] == 0) begin
         esl[last] = 1;
         total += 1;
      end
      case (fault)
         FaultShortLen:
            sec_len = $urandom_range(0, int'(ts_pmt_pkg::FixedHdrBytes) - 1 + pil);
         FaultTypeOverrun:
            sec_len = total + $urandom_range(1, int'(ts_pmt_pkg::EntryHdrBytes) - 1);
         FaultEsOverrun:   sec_len = total - $urandom_range(1, esl[last]);
         default:          sec_len = total;
      endcase
      if (sec_len > MaxSectionLen)
         sec_len = MaxSectionLen;

      len10 = 10'(sec_len);
      body.push_back(fill_byte(pat));              // table id
      body.push_back(len_hi_byte(pat, len10));
      body.push_back(len10[7:0]);
      repeat (6) body.push_back(fill_byte(pat));   // program, version, sec, last, pcr hi
      body.push_back(fill_byte(pat));              // pcr lo
      len10 = 10'(pil);
      body.push_back(len_hi_byte(pat, len10));
      body.push_back(len10[7:0]);
      repeat (pil) body.push_back(fill_byte(pat));
      for (int i = 0; i < n_ent; i++) begin
         body.push_back((pat == PatRandom) ? pick_stream_type() : fill_byte(pat));
         body.push_back(fill_byte(pat));
         body.push_back(fill_byte(pat));
         len10 = 10'(esl[i]);
         body.push_back(len_hi_byte(pat, len10));
         body.push_back(len10[7:0]);
         repeat (esl[i]) body.push_back(fill_byte(pat));
      end
      repeat (4) body.push_back(fill_byte(pat));   // crc

      cut = (fault == FaultRestart) ? $urandom_range(0, body.size() - 1) : body.size();
      offer_section_byte(fill_byte(pat), 1'b1);
      for (int i = 0; i < cut; i++)
         offer_section_byte(body[i], 1'b0);
      sections_sent++;
      if (fault != FaultNone)
         sections_faulted++;
      // Stray bytes between sections must be dropped.
      if (fault != FaultRestart && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) offer_section_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_random_section();
      section_fault_type fault;
      fill_pattern_type  pat;
      int                r;
      r = $urandom_range(0, 99);
      if (r < 60)      fault = FaultNone;
      else if (r < 70) fault = FaultShortLen;
      else if (r < 78) fault = FaultTypeOverrun;
      else if (r < 88) fault = FaultEsOverrun;
      else             fault = FaultRestart;
      r = $urandom_range(0, 19);
      pat = (r == 0) ? PatOnes : (r == 1) ? PatZeros : PatRandom;
      send_pmt_section(($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0,
                       $urandom_range(0, 4), $urandom_range(0, 6), fault, pat);
   endtask

   initial begin
      int  phase_start;
      bit  hold_done;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: stray byte while waiting, all-ones minimal section,
      // all-zeros short length, a small section with entries.
      offer_section_byte(8'hA5, 1'b0);
      send_pmt_section(0, 0, 0, FaultNone, PatOnes);
      send_pmt_section(0, 0, 0, FaultShortLen, PatZeros);
      send_pmt_section(1, 2, 2, FaultNone, PatRandom);
      stop_offering();
      wait_all_fields();

      hold_done = 1'b0;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BytesPerPhase) begin
            if (!hold_done && bytes_sent - phase_start > 60) begin
               hold_off_req = 1'b1;
               hold_done = 1'b1;
            end
            send_random_section();
         end
         stop_offering();
         wait_all_fields();
      end

      repeat (DrainCycles) @(posedge clock);
      $display("Covered %0d bytes in %0d sections (%0d faulted or cut short),",
               bytes_sent, sections_sent, sections_faulted);
      $display({"over four flow-control phases and one long receiver hold-off;",
                " %0d records checked"}, fields_checked);
      if (mismatch_count == 0 && fields_pending == 0)
         $display("ts_pmt_section_parser test passed");
      else
         $display("ts_pmt_section_parser test failed");
      $finish;
   end

endmodule
